// ----- src/pipeline_hazard_nop_inserter_macros.svh -----
// Assertion macros shared by the hazard NOP inserter modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef PIPELINE_HAZARD_NOP_INSERTER_MACROS_SVH
`define PIPELINE_HAZARD_NOP_INSERTER_MACROS_SVH

`define PHNI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PHNI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/phni_pkg.sv -----
package phni_pkg;

    localparam logic [31:0] NOP_WORD = 32'h0000_0013;

    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  bubbles;
    } queue_entry_t;

    function automatic logic word_reads(input logic [31:0] w, input logic [4:0] r);
        logic [6:0] opc;
        logic [4:0] rs1;
        logic [4:0] rs2;
        logic       hit;
        opc = w[6:0];
        rs1 = w[19:15];
        rs2 = w[24:20];
        if (opc == OPC_OP || opc == OPC_BRANCH || opc == OPC_STORE)
        begin
            hit = (rs1 == r) || (rs2 == r);
        end
        else if (opc == OPC_LOAD || opc == OPC_OPIMM)
        begin
            hit = (rs1 == r);
        end
        else
        begin
            hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic logic word_produces(input logic [31:0] w, input logic fwd);
        logic [6:0] opc;
        logic       prod;
        opc = w[6:0];
        if (w == NOP_WORD || w[11:7] == 5'd0)
        begin
            prod = 1'b0;
        end
        else if (fwd)
        begin
            prod = (opc == OPC_LOAD);
        end
        else
        begin
            prod = (opc == OPC_LOAD) || (opc == OPC_OP) || (opc == OPC_OPIMM) ||
                   (opc == OPC_JAL) || (opc == OPC_LUI);
        end
        return prod;
    endfunction

endpackage

// ----- src/phni_front.sv -----
`include "pipeline_hazard_nop_inserter_macros.svh"

module phni_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  instr_valid,
    output logic                  instr_stall,
    input  logic [31:0]           instr_word,
    input  logic                  queue_full,
    output logic                  push,
    output phni_pkg::queue_entry_t push_entry
);
    import phni_pkg::*;

    logic       fwd_mode_reg;
    logic [4:0] near_dest_reg;
    logic       near_valid_reg;
    logic [4:0] far_dest_reg;
    logic       far_valid_reg;
    logic [4:0] near_dest_next;
    logic       near_valid_next;
    logic [4:0] far_dest_next;
    logic       far_valid_next;
    logic [1:0] bubbles;
    logic       prod;
    logic       accept;

    assign cfg_ready   = 1'b1;
    assign instr_stall = queue_full;
    assign accept      = instr_valid && !queue_full;

    always_comb
    begin
        priority if (near_valid_reg && word_reads(instr_word, near_dest_reg))
        begin
            bubbles = 2'd2;
        end
        else if (far_valid_reg && word_reads(instr_word, far_dest_reg))
        begin
            bubbles = 2'd1;
        end
        else
        begin
            bubbles = 2'd0;
        end
    end

    assign prod = word_produces(instr_word, fwd_mode_reg);

    always_comb
    begin
        if (bubbles != 2'd0)
        begin
            far_dest_next  = 5'd0;
            far_valid_next = 1'b0;
        end
        else
        begin
            far_dest_next  = near_dest_reg;
            far_valid_next = near_valid_reg;
        end
        near_dest_next  = prod ? instr_word[11:7] : 5'd0;
        near_valid_next = prod;
    end

    assign push               = accept;
    assign push_entry.word    = instr_word;
    assign push_entry.bubbles = bubbles;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_mode_reg   <= 1'b0;
            near_dest_reg  <= 5'd0;
            near_valid_reg <= 1'b0;
            far_dest_reg   <= 5'd0;
            far_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fwd_mode_reg <= cfg_data;
            end
            if (accept)
            begin
                near_dest_reg  <= near_dest_next;
                near_valid_reg <= near_valid_next;
                far_dest_reg   <= far_dest_next;
                far_valid_reg  <= far_valid_next;
            end
        end
    end

    // A register x0 destination must never be recorded as a producer.
    `PHNI_ASSERT_SAME(a_near_not_x0, near_valid_reg, near_dest_reg != 5'd0, "near producer is x0")
    `PHNI_ASSERT_SAME(a_far_not_x0, far_valid_reg, far_dest_reg != 5'd0, "far producer is x0")
    `PHNI_ASSERT_NEXT(a_bubble_clears_far, accept && bubbles != 2'd0, !far_valid_reg, "far slot kept after bubbles")

endmodule

// ----- src/phni_queue.sv -----
`include "pipeline_hazard_nop_inserter_macros.svh"

module phni_queue #(
    parameter int DEPTH = phni_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  phni_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   empty,
    output phni_pkg::queue_entry_t head
);
    import phni_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    queue_entry_t     slots_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PHNI_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= FULL_CNT, "queue count overflow")
    `PHNI_ASSERT_SAME(a_no_push_full, push, !full, "push into full queue")
    `PHNI_ASSERT_SAME(a_no_pop_empty, pop, !empty, "pop from empty queue")

endmodule

// ----- src/phni_back.sv -----
`include "pipeline_hazard_nop_inserter_macros.svh"

module phni_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   queue_empty,
    input  phni_pkg::queue_entry_t head,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [31:0]            out_word,
    output logic                   is_bubble,
    output logic                   last_of_run
);
    import phni_pkg::*;

    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic        is_bubble_reg;
    logic        last_reg;
    logic [1:0]  sent_reg;
    logic [1:0]  sent_next;
    logic        load;
    logic        emit_word;

    assign load      = !queue_empty && (!out_valid_reg || !result_stall);
    assign emit_word = (sent_reg == head.bubbles);
    assign pop       = load && emit_word;

    always_comb
    begin
        sent_next = sent_reg;
        if (load)
        begin
            sent_next = emit_word ? 2'd0 : sent_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg  <= emit_word ? head.word : NOP_WORD;
            is_bubble_reg <= !emit_word;
            last_reg      <= emit_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sent_reg      <= 2'd0;
        end
        else
        begin
            sent_reg <= sent_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign out_word     = out_word_reg;
    assign is_bubble    = is_bubble_reg;
    assign last_of_run  = last_reg;

    `PHNI_ASSERT_SAME(a_kind_excl, out_valid_reg, is_bubble_reg != last_reg, "bubble and last mixed")
    `PHNI_ASSERT_SAME(a_bubble_nop, out_valid_reg && is_bubble_reg, out_word_reg == NOP_WORD, "bubble is not NOP")
    `PHNI_ASSERT_SAME(a_sent_bound, 1'b1, sent_reg <= 2'd2, "too many bubbles sent")

endmodule

// ----- src/pipeline_hazard_nop_inserter.sv -----
// Hazard NOP inserter for a RISC-V instruction stream.
// Instruction words enter on instr_valid/instr_stall; each one leaves on
// result_valid/result_stall, preceded by zero, one or two inserted NOP items
// when it reads a register written by one of the two previously emitted slots.
// An item is taken at a clock edge where valid is high and stall is low.
// The single configuration register, forwarding_mode, is written through
// cfg_valid/cfg_ready/cfg_data; the user must write it only while the block is
// idle, which the block does not enforce; cfg_ready is always high.
// The output emits one result per cycle unless stalled, so an item needing n
// NOPs gives n + 1 results; the checker takes one item per unstalled cycle.
// A two-entry queue sits between the checker and the output sequencer, so the
// input keeps accepting while the receiver stalls until that queue fills.
// When the receiver stalls, the presented result holds until it is taken.
// Reset clears the hazard history, the queue, the output and forwarding_mode.
module pipeline_hazard_nop_inserter #(
    parameter int QUEUE_DEPTH = phni_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        instr_valid,
    output logic        instr_stall,
    input  logic [31:0] instr_word,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] out_word,
    output logic        is_bubble,
    output logic        last_of_run
);
    import phni_pkg::*;

    logic         push;
    queue_entry_t push_entry;
    logic         queue_full;
    logic         queue_empty;
    logic         pop;
    queue_entry_t head;

    phni_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .instr_valid (instr_valid),
        .instr_stall (instr_stall),
        .instr_word  (instr_word),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    phni_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .head       (head)
    );

    phni_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_word     (out_word),
        .is_bubble    (is_bubble),
        .last_of_run  (last_of_run)
    );

endmodule

// ----- dv/hazard_nop_checker.sv -----
module hazard_nop_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        instr_valid,
    input  logic        instr_stall,
    input  logic [31:0] instr_word,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] out_word,
    input  logic        is_bubble,
    input  logic        last_of_run,
    output int          error_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import phni_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic        bubble;
        logic        last;
    } emitted_t;

    emitted_t    emitted_q[$];
    logic        loads_only;
    logic [4:0]  near_rd;
    logic [4:0]  far_rd;
    logic        near_live;
    logic        far_live;
    int          mismatches;

    function automatic logic reads_reg(input logic [31:0] w, input logic [4:0] r);
        logic hit;
        case (w[6:0])
            OPC_OP, OPC_BRANCH, OPC_STORE: hit = (w[19:15] == r) || (w[24:20] == r);
            OPC_LOAD, OPC_OPIMM:           hit = (w[19:15] == r);
            default:                       hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic writes_reg(input logic [31:0] w, input logic only_loads);
        logic prod;
        if (w == NOP_WORD || w[11:7] == 5'd0)
        begin
            prod = 1'b0;
        end
        else if (only_loads)
        begin
            prod = (w[6:0] == OPC_LOAD);
        end
        else
        begin
            case (w[6:0])
                OPC_LOAD, OPC_OP, OPC_OPIMM, OPC_JAL, OPC_LUI: prod = 1'b1;
                default:                                       prod = 1'b0;
            endcase
        end
        return prod;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        emitted_t got;
        emitted_t want;
        int       bubbles;
        logic     prod;
        if (!rst_n)
        begin
            emitted_q.delete();
            loads_only    = 1'b0;
            near_rd       = '0;
            far_rd        = '0;
            near_live     = 1'b0;
            far_live      = 1'b0;
            mismatches    = 0;
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            // Results leave before the item taken at this edge can produce any.
            if (result_valid && !result_stall)
            begin
                got = emitted_t'{out_word, is_bubble, last_of_run};
                if (emitted_q.size() == 0)
                begin
                    $error("unexpected result item: out_word %h", out_word);
                    mismatches++;
                end
                else
                begin
                    want = emitted_q.pop_front();
                    if (got.word !== want.word)
                    begin
                        $error("out_word: expected %h, actual %h", want.word, got.word);
                        mismatches++;
                    end
                    if (got.bubble !== want.bubble)
                    begin
                        $error("is_bubble: expected %b, actual %b", want.bubble, got.bubble);
                        mismatches++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_of_run: expected %b, actual %b", want.last, got.last);
                        mismatches++;
                    end
                end
            end

            if (instr_valid && !instr_stall)
            begin
                bubbles = 0;
                if (near_live && reads_reg(instr_word, near_rd))
                begin
                    bubbles = 2;
                end
                else if (far_live && reads_reg(instr_word, far_rd))
                begin
                    bubbles = 1;
                end
                repeat (bubbles) emitted_q.push_back(emitted_t'{NOP_WORD, 1'b1, 1'b0});
                emitted_q.push_back(emitted_t'{instr_word, 1'b0, 1'b1});

                prod = writes_reg(instr_word, loads_only);
                if (bubbles > 0)
                begin
                    far_rd   = '0;
                    far_live = 1'b0;
                end
                else
                begin
                    far_rd   = near_rd;
                    far_live = near_live;
                end
                near_rd   = prod ? instr_word[11:7] : 5'd0;
                near_live = prod;
            end

            // A mode written at this edge applies from the next item on.
            if (cfg_valid && cfg_ready)
            begin
                loads_only = cfg_data;
            end

            error_count   <= mismatches;
            pending_count <= emitted_q.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import phni_pkg::*;

    localparam logic [6:0] OPC_CUSTOM0 = 7'b0001011;
    localparam int         STALL_LIMIT = 2000;
    localparam int         HOLD_AT     = 250;
    localparam int         HOLD_CYCLES = 60;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        instr_valid;
    logic        instr_stall;
    logic [31:0] instr_word;
    logic        result_valid;
    logic        result_stall;
    logic [31:0] out_word;
    logic        is_bubble;
    logic        last_of_run;

    int   error_count;
    int   pending_count;
    int   idle_cycles;
    int   taken_items;
    logic quiet;
    logic hold_done;

    always #1 clk = ~clk;

    pipeline_hazard_nop_inserter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr_word   (instr_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_word     (out_word),
        .is_bubble    (is_bubble),
        .last_of_run  (last_of_run)
    );

    hazard_nop_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .instr_valid   (instr_valid),
        .instr_stall   (instr_stall),
        .instr_word    (instr_word),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .out_word      (out_word),
        .is_bubble     (is_bubble),
        .last_of_run   (last_of_run),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    function automatic logic [31:0] encode(input logic [6:0] opc, input logic [4:0] rd,
                                           input logic [4:0] rs1, input logic [4:0] rs2);
        logic [31:0] w;
        w        = $urandom;
        w[6:0]   = opc;
        w[11:7]  = rd;
        w[19:15] = rs1;
        w[24:20] = rs2;
        return w;
    endfunction

    function automatic logic [31:0] random_word();
        logic [6:0] opc;
        int         pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            return $urandom;
        end
        if (pick == 1)
        begin
            return NOP_WORD;
        end
        case ($urandom_range(0, 7))
            0:       opc = OPC_LOAD;
            1:       opc = OPC_OP;
            2:       opc = OPC_OPIMM;
            3:       opc = OPC_JAL;
            4:       opc = OPC_LUI;
            5:       opc = OPC_BRANCH;
            6:       opc = OPC_STORE;
            default: opc = OPC_CUSTOM0;
        endcase
        // A few registers in play make back-to-back dependencies common.
        if ($urandom_range(0, 3) == 0)
        begin
            return encode(opc, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 31)));
        end
        return encode(opc, 5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)),
                      5'($urandom_range(0, 3)));
    endfunction

    task automatic send_word(input logic [31:0] w);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            instr_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        instr_valid <= 1'b1;
        instr_word  <= w;
        @(posedge clk);
        while (instr_stall) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_word(random_word());
    endtask

    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        instr_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
            taken_items <= 0;
        end
        else
        begin
            if (instr_valid && !instr_stall)
            begin
                taken_items <= taken_items + 1;
            end
            if ((instr_valid && !instr_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        result_stall = 1'b0;
        hold_done    = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!hold_done && taken_items >= HOLD_AT)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(0, 3) == 0);
                repeat ($urandom_range(1, 18))
                begin
                    if (!quiet)
                    begin
                        @(posedge clk);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        instr_valid = 1'b0;
        instr_word  = '0;
        quiet       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(NOP_WORD);
        send_word(encode(OPC_OPIMM, 5'd1, 5'd0, 5'd0));
        send_word(encode(OPC_OP, 5'd2, 5'd1, 5'd1));
        send_word(encode(OPC_STORE, 5'd0, 5'd9, 5'd2));
        send_word(encode(OPC_LUI, 5'd3, 5'd0, 5'd0));
        send_word(encode(OPC_JAL, 5'd4, 5'd0, 5'd0));
        send_word(encode(OPC_BRANCH, 5'd0, 5'd3, 5'd7));
        send_word(encode(OPC_LOAD, 5'd5, 5'd0, 5'd0));
        send_word(encode(OPC_OPIMM, 5'd6, 5'd9, 5'd5));
        send_word(encode(OPC_LOAD, 5'd7, 5'd5, 5'd0));
        send_word(encode(OPC_OPIMM, 5'd10, 5'd0, 5'd0));
        send_word(encode(OPC_OPIMM, 5'd11, 5'd0, 5'd0));
        send_word(encode(OPC_OP, 5'd12, 5'd10, 5'd11));
        send_word(encode(OPC_OPIMM, 5'd0, 5'd0, 5'd0));
        send_word(encode(OPC_OP, 5'd13, 5'd0, 5'd0));
        send_word(encode(OPC_LOAD, 5'd14, 5'd0, 5'd0));
        send_word(encode(OPC_CUSTOM0, 5'd15, 5'd14, 5'd14));
        send_word(encode(OPC_OP, 5'd16, 5'd14, 5'd0));
        send_word(encode(OPC_JAL, 5'd31, 5'd31, 5'd31));
        send_word(encode(OPC_OP, 5'd31, 5'd31, 5'd31));
        send_word(encode(OPC_OPIMM, 5'd17, 5'd0, 5'd0));
        send_word(NOP_WORD);
        send_word(encode(OPC_STORE, 5'd0, 5'd17, 5'd0));
        drain();

        write_mode(1'b1);
        send_random(150);
        drain();

        write_mode(1'b0);
        send_random(150);
        drain();

        write_mode(1'b1);
        send_random(110);
        quiet <= 1'b1;
        send_random(50);
        drain();

        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- pipeline_hazard_nop_inserter.f -----
+incdir+src
src/phni_pkg.sv
src/phni_front.sv
src/phni_queue.sv
src/phni_back.sv
src/pipeline_hazard_nop_inserter.sv
dv/hazard_nop_checker.sv
dv/testbench.sv
